>>> hdl/od_command_removal_id_parser_top_assert.svh
// Assertion macros shared by the checker of the removal command parser.
// The first two macros expect clk and rst in scope; the third needs only clk.
`ifndef OD_COMMAND_REMOVAL_ID_PARSER_TOP_ASSERT_SVH
`define OD_COMMAND_REMOVAL_ID_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset
`define ODCRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define ODCRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define ODCRP_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/odcrp_pkg.sv
`timescale 1ns / 1ps

package odcrp_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 28;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Longest size field in bytes
  localparam int MAX_SIZE_BYTES = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_OD_TAG   = 2'd0;
  localparam logic [1:0] REG_ESD_TAG  = 2'd1;
  localparam logic [1:0] REG_IPMP_TAG = 2'd2;

  // Tag reset values
  localparam logic [7:0] OD_TAG_RST   = 8'd2;
  localparam logic [7:0] ESD_TAG_RST  = 8'd4;
  localparam logic [7:0] IPMP_TAG_RST = 8'd6;

  // Result kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_OD    = 3'd1;
  localparam logic [2:0] KIND_OWNER = 3'd2;
  localparam logic [2:0] KIND_ES    = 3'd3;
  localparam logic [2:0] KIND_IPMP  = 3'd4;

  // End-of-command status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_SIZE_LONG = 2'd2;
  localparam logic [1:0] ST_SKIPPED   = 2'd3;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_OD,
    CLS_ESD,
    CLS_IPMP
  } cls_t;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_SIZE,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> hdl/odcrp_front.sv
`timescale 1ns / 1ps

module odcrp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [odcrp_pkg::ADDR_W-1:0]  paddr,
  input  logic [odcrp_pkg::DATA_W-1:0]  pwdata,
  output logic [odcrp_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [odcrp_pkg::BYTE_W-1:0]  in_byte,
  input  odcrp_pkg::q_status_t          q_status,
  output logic                          push,
  output odcrp_pkg::q_entry_t           push_entry
);
  import odcrp_pkg::*;

  logic [7:0] od_tag;
  logic [7:0] esd_tag;
  logic [7:0] ipmp_tag;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Write the tag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      od_tag   <= OD_TAG_RST;
      esd_tag  <= ESD_TAG_RST;
      ipmp_tag <= IPMP_TAG_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OD_TAG:   od_tag   <= pwdata[7:0];
        REG_ESD_TAG:  esd_tag  <= pwdata[7:0];
        REG_IPMP_TAG: ipmp_tag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the tag registers
  always_comb begin
    unique case (reg_idx)
      REG_OD_TAG:   prdata = {24'd0, od_tag};
      REG_ESD_TAG:  prdata = {24'd0, esd_tag};
      REG_IPMP_TAG: prdata = {24'd0, ipmp_tag};
      default:      prdata = '0;
    endcase
  end

  // Classify every byte as if it were a tag; OD wins over ESD over IPMP
  always_comb begin
    push_entry.data = in_byte;
    if (in_byte == od_tag) begin
      push_entry.cls = CLS_OD;
    end else if (in_byte == esd_tag) begin
      push_entry.cls = CLS_ESD;
    end else if (in_byte == ipmp_tag) begin
      push_entry.cls = CLS_IPMP;
    end else begin
      push_entry.cls = CLS_OTHER;
    end
  end

  // Hold the stream while the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid & ~q_status.full;

endmodule

>>> hdl/odcrp_queue.sv
`timescale 1ns / 1ps

module odcrp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  odcrp_pkg::q_entry_t  push_entry,
  input  logic                 pop,
  output odcrp_pkg::q_entry_t  pop_entry,
  output odcrp_pkg::q_status_t q_status
);
  import odcrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign do_push        = push & ~q_status.full;
  assign do_pop         = pop & ~q_status.empty;
  assign pop_entry      = entries[rd_ptr];

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/odcrp_back.sv
`timescale 1ns / 1ps

module odcrp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  odcrp_pkg::q_entry_t             pop_entry,
  input  odcrp_pkg::q_status_t            q_status,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [odcrp_pkg::KIND_W-1:0]    kind,
  output logic [odcrp_pkg::ID_W-1:0]      id_value,
  output logic [odcrp_pkg::BYTE_W-1:0]    cmd_tag,
  output logic                            cmd_last,
  output logic [odcrp_pkg::STATUS_W-1:0]  cmd_status,
  output logic [odcrp_pkg::SIZE_W-1:0]    payload_size
);
  import odcrp_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  cls_t        held_cls, held_cls_next;
  logic [7:0]  held_tag, held_tag_next;
  logic [27:0] size_accum, size_accum_next;
  logic [2:0]  size_bytes_seen, size_bytes_seen_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [16:0] bit_accum, bit_accum_next;
  logic [4:0]  bits_held, bits_held_next;
  logic [1:0]  payload_index, payload_index_next;

  // Result of the current byte
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [15:0] res_id;
  logic        res_last;
  logic [1:0]  res_status;

  // Working values
  logic [7:0]  b;
  logic [27:0] size_shift;
  logic [2:0]  seen_inc;
  logic [27:0] left_dec;
  logic        last;
  logic [16:0] od_acc;
  logic [4:0]  od_bits;
  logic [4:0]  od_rem;
  logic [16:0] od_shift;
  logic [16:0] od_mask;

  assign b   = pop_entry.data;
  assign pop = ~q_status.empty & (~out_valid | ~out_stall);

  assign size_shift = {size_accum[20:0], b[6:0]};
  assign seen_inc   = size_bytes_seen + 3'd1;
  assign left_dec   = (bytes_left != '0) ? bytes_left - 28'd1 : '0;
  assign last       = (left_dec == '0);

  // Bit packer for 10-bit object descriptor ids
  assign od_acc   = {bit_accum[8:0], b};
  assign od_bits  = bits_held + 5'd8;
  assign od_rem   = od_bits - 5'd10;
  assign od_shift = od_acc >> od_rem;
  assign od_mask  = (17'd1 << od_rem) - 17'd1;

  // Next parser state and result of one byte
  always_comb begin
    phase_next           = phase;
    held_cls_next        = held_cls;
    held_tag_next        = held_tag;
    size_accum_next      = size_accum;
    size_bytes_seen_next = size_bytes_seen;
    bytes_left_next      = bytes_left;
    bit_accum_next       = bit_accum;
    bits_held_next       = bits_held;
    payload_index_next   = payload_index;
    res_valid            = 1'b0;
    res_kind             = KIND_NONE;
    res_id               = '0;
    res_last             = 1'b0;
    res_status           = ST_OK;

    unique case (phase)
      PH_SIZE: begin
        size_accum_next      = size_shift;
        size_bytes_seen_next = seen_inc;
        if (b[7]) begin
          // Continuation set on the last allowed size byte ends the command
          if (seen_inc >= 3'(MAX_SIZE_BYTES)) begin
            phase_next = PH_TAG;
            res_valid  = 1'b1;
            res_last   = 1'b1;
            res_status = ST_SIZE_LONG;
          end
        end else if (size_shift == '0) begin
          // Empty payload ends the command here
          phase_next = PH_TAG;
          res_valid  = 1'b1;
          res_last   = 1'b1;
          unique case (held_cls)
            CLS_OTHER: res_status = ST_SKIPPED;
            CLS_ESD:   res_status = ST_BAD_LEN;
            default:   res_status = ST_OK;
          endcase
        end else begin
          phase_next         = PH_PAYLOAD;
          bytes_left_next    = size_shift;
          bit_accum_next     = '0;
          bits_held_next     = '0;
          payload_index_next = '0;
        end
      end

      PH_PAYLOAD: begin
        bytes_left_next = left_dec;
        res_last        = last;
        if (last) begin
          phase_next = PH_TAG;
        end
        unique case (held_cls)
          CLS_OD: begin
            if (od_bits >= 5'd10) begin
              bits_held_next = od_rem;
              bit_accum_next = od_acc & od_mask;
              res_valid      = 1'b1;
              res_kind       = KIND_OD;
              res_id         = {6'd0, od_shift[9:0]};
              res_status     = (od_rem >= 5'd8) ? ST_BAD_LEN : ST_OK;
            end else begin
              bits_held_next = od_bits;
              bit_accum_next = od_acc;
              res_valid      = last;
              res_status     = (od_bits >= 5'd8) ? ST_BAD_LEN : ST_OK;
            end
          end
          CLS_ESD: begin
            case (payload_index)
              2'd0: begin
                bit_accum_next     = {9'd0, b};
                payload_index_next = 2'd1;
                res_valid          = last;
                res_status         = ST_BAD_LEN;
              end
              2'd1: begin
                payload_index_next = 2'd2;
                res_valid          = 1'b1;
                res_kind           = KIND_OWNER;
                res_id             = {6'd0, bit_accum[7:0], b[7:6]};
              end
              2'd2: begin
                bit_accum_next     = {9'd0, b};
                payload_index_next = 2'd3;
                res_valid          = last;
              end
              default: begin
                payload_index_next = 2'd2;
                res_valid          = 1'b1;
                res_kind           = KIND_ES;
                res_id             = {bit_accum[7:0], b};
              end
            endcase
          end
          CLS_IPMP: begin
            res_valid = 1'b1;
            res_kind  = KIND_IPMP;
            res_id    = {8'd0, b};
          end
          default: begin
            res_valid  = last;
            res_status = ST_SKIPPED;
          end
        endcase
      end

      default: begin
        // Waiting for tag; the unused phase code lands here too
        held_tag_next        = b;
        held_cls_next        = pop_entry.cls;
        size_accum_next      = '0;
        size_bytes_seen_next = '0;
        bytes_left_next      = '0;
        bit_accum_next       = '0;
        bits_held_next       = '0;
        payload_index_next   = '0;
        phase_next           = PH_SIZE;
      end
    endcase
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TAG;
    end else if (pop) begin
      phase <= phase_next;
    end
  end

  // Parser working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_cls        <= CLS_OTHER;
      held_tag        <= '0;
      size_accum      <= '0;
      size_bytes_seen <= '0;
      bytes_left      <= '0;
      bit_accum       <= '0;
      bits_held       <= '0;
      payload_index   <= '0;
    end else if (pop) begin
      held_cls        <= held_cls_next;
      held_tag        <= held_tag_next;
      size_accum      <= size_accum_next;
      size_bytes_seen <= size_bytes_seen_next;
      bytes_left      <= bytes_left_next;
      bit_accum       <= bit_accum_next;
      bits_held       <= bits_held_next;
      payload_index   <= payload_index_next;
    end
  end

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind         <= res_kind;
      id_value     <= res_id;
      cmd_tag      <= held_tag;
      cmd_last     <= res_last;
      cmd_status   <= res_last ? res_status : ST_OK;
      payload_size <= size_accum_next;
    end
  end

endmodule

>>> hdl/od_command_removal_id_parser_top.sv
// Removal command parser: one stream byte per cycle sustained while out_stall
// does not hold the output. Each byte is written into the queue, then the back
// end's parser step consumes it and loads any result into the output register.
// The parser takes a new byte whenever its output register is empty or taken.
// Reset (rst, synchronous, active high): tags to 2/4/6, parser waits for a
// tag, queue and output register empty.
`timescale 1ns / 1ps

module od_command_removal_id_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [odcrp_pkg::ADDR_W-1:0]    paddr,
  input  logic [odcrp_pkg::DATA_W-1:0]    pwdata,
  output logic [odcrp_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [odcrp_pkg::BYTE_W-1:0]    in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [odcrp_pkg::KIND_W-1:0]    kind,
  output logic [odcrp_pkg::ID_W-1:0]      id_value,
  output logic [odcrp_pkg::BYTE_W-1:0]    cmd_tag,
  output logic                            cmd_last,
  output logic [odcrp_pkg::STATUS_W-1:0]  cmd_status,
  output logic [odcrp_pkg::SIZE_W-1:0]    payload_size
);
  import odcrp_pkg::*;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  pop_entry;
  logic      push;
  logic      pop;

  odcrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  odcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  odcrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_entry    (pop_entry),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .id_value     (id_value),
    .cmd_tag      (cmd_tag),
    .cmd_last     (cmd_last),
    .cmd_status   (cmd_status),
    .payload_size (payload_size)
  );

endmodule

>>> hdl/odcrp_checker.sv
`timescale 1ns / 1ps
`include "od_command_removal_id_parser_top_assert.svh"

module odcrp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [odcrp_pkg::KIND_W-1:0]    kind,
  input logic [odcrp_pkg::ID_W-1:0]      id_value,
  input logic                            cmd_last,
  input logic [odcrp_pkg::STATUS_W-1:0]  cmd_status
);
  import odcrp_pkg::*;

  // A result without an id only ever closes a command, and carries a zero id
  `ODCRP_ASSERT_IMP(a_none_is_end, out_valid && kind == KIND_NONE, cmd_last && id_value == '0, "empty result does not end a command")

  // Status is only reported on the closing byte
  `ODCRP_ASSERT_IMP(a_status_at_end, out_valid && !cmd_last, cmd_status == ST_OK, "status set before command end")

  // A stalled result holds
  `ODCRP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(id_value) && $stable(cmd_last) && $stable(cmd_status), "stalled result changed")

  // Nothing is offered straight after reset
  `ODCRP_ASSERT_RST(a_rst_empty, rst, !out_valid, "result valid after reset")

endmodule

bind od_command_removal_id_parser_top odcrp_checker u_checker (.*);

>>> tb/tb_od_command_removal_id_parser_top.sv
`timescale 1ns / 1ps

module tb_od_command_removal_id_parser_top;
  import odcrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_BYTES    = 290;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     id;
    logic [BYTE_W-1:0]   tag;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
  } id_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     id_value;
  logic [BYTE_W-1:0]   cmd_tag;
  logic                cmd_last;
  logic [STATUS_W-1:0] cmd_status;
  logic [SIZE_W-1:0]   payload_size;

  // Stream bytes waiting to be sent, and identifiers the parser still owes
  logic [BYTE_W-1:0] byte_queue [$];
  id_result_t        expected_ids [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the tag registers
  logic [7:0] od_tag_cfg   = OD_TAG_RST;
  logic [7:0] esd_tag_cfg  = ESD_TAG_RST;
  logic [7:0] ipmp_tag_cfg = IPMP_TAG_RST;

  // Shadow of the parser state
  phase_t       parse_phase = PH_TAG;
  logic [7:0]   cur_tag     = '0;
  logic [27:0]  size_acc    = '0;
  logic [2:0]   size_count  = '0;
  logic [27:0]  bytes_left  = '0;
  logic [16:0]  bit_acc     = '0;
  logic [4:0]   bit_count   = '0;
  logic [1:0]   esd_index   = '0;

  logic [7:0] directed_bytes [26] = '{
    8'h02, 8'h00,                      // OD remove, zero size
    8'h04, 8'h00,                      // ESD remove, zero size
    8'h07, 8'h00,                      // unknown tag, zero size
    8'h04, 8'h01, 8'hFF,               // ESD remove of one byte
    8'h04, 8'h03, 8'hFF, 8'hC0, 8'h00, // ESD remove with odd trailing byte
    8'h02, 8'h01, 8'hFF,               // OD remove with 8 bits left over
    8'h06, 8'h02, 8'h00, 8'hFF,        // IPMP remove
    8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF  // size field too long
  };

  od_command_removal_id_parser_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .id_value     (id_value),
    .cmd_tag      (cmd_tag),
    .cmd_last     (cmd_last),
    .cmd_status   (cmd_status),
    .payload_size (payload_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cls_t classify(input logic [7:0] t);
    if (t == od_tag_cfg) return CLS_OD;
    if (t == esd_tag_cfg) return CLS_ESD;
    if (t == ipmp_tag_cfg) return CLS_IPMP;
    return CLS_OTHER;
  endfunction

  task automatic queue_result(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] idv,
                              input logic fin, input logic [STATUS_W-1:0] st);
    id_result_t r;
    r.kind   = k;
    r.id     = idv;
    r.tag    = cur_tag;
    r.last   = fin;
    r.status = fin ? st : ST_OK;
    r.size   = size_acc;
    expected_ids.push_back(r);
  endtask

  // Advance the shadow parser by one stream byte
  task automatic predict_byte(input logic [7:0] b);
    cls_t c;
    logic fin;
    logic [16:0] shifted;
    case (parse_phase)
      PH_SIZE: begin
        size_acc   = {size_acc[20:0], b[6:0]};
        size_count = size_count + 3'd1;
        if (b[7]) begin
          if (size_count >= MAX_SIZE_BYTES) begin
            parse_phase = PH_TAG;
            queue_result(KIND_NONE, '0, 1'b1, ST_SIZE_LONG);
          end
        end else if (size_acc == '0) begin
          parse_phase = PH_TAG;
          c = classify(cur_tag);
          queue_result(KIND_NONE, '0, 1'b1,
                       c == CLS_OTHER ? ST_SKIPPED : (c == CLS_ESD ? ST_BAD_LEN : ST_OK));
        end else begin
          parse_phase = PH_PAYLOAD;
          bytes_left  = size_acc;
          bit_acc     = '0;
          bit_count   = '0;
          esd_index   = '0;
        end
      end
      PH_PAYLOAD: begin
        c = classify(cur_tag);
        if (bytes_left != '0) bytes_left = bytes_left - 28'd1;
        fin = (bytes_left == '0);
        if (fin) parse_phase = PH_TAG;
        case (c)
          CLS_OD: begin
            bit_acc   = {bit_acc[8:0], b};
            bit_count = bit_count + 5'd8;
            if (bit_count >= 5'd10) begin
              bit_count = bit_count - 5'd10;
              shifted   = bit_acc >> bit_count;
              bit_acc   = bit_acc & ((17'd1 << bit_count) - 17'd1);
              queue_result(KIND_OD, {6'd0, shifted[9:0]}, fin,
                           bit_count >= 5'd8 ? ST_BAD_LEN : ST_OK);
            end else if (fin) begin
              queue_result(KIND_NONE, '0, 1'b1, bit_count >= 5'd8 ? ST_BAD_LEN : ST_OK);
            end
          end
          CLS_ESD: begin
            case (esd_index)
              2'd0: begin
                bit_acc   = {9'd0, b};
                esd_index = 2'd1;
                if (fin) queue_result(KIND_NONE, '0, 1'b1, ST_BAD_LEN);
              end
              2'd1: begin
                esd_index = 2'd2;
                queue_result(KIND_OWNER, {6'd0, bit_acc[7:0], b[7:6]}, fin, ST_OK);
              end
              2'd2: begin
                bit_acc   = {9'd0, b};
                esd_index = 2'd3;
                if (fin) queue_result(KIND_NONE, '0, 1'b1, ST_OK);
              end
              default: begin
                esd_index = 2'd2;
                queue_result(KIND_ES, {bit_acc[7:0], b}, fin, ST_OK);
              end
            endcase
          end
          CLS_IPMP: queue_result(KIND_IPMP, {8'd0, b}, fin, ST_OK);
          default: begin
            if (fin) queue_result(KIND_NONE, '0, 1'b1, ST_SKIPPED);
          end
        endcase
      end
      default: begin
        cur_tag     = b;
        size_acc    = '0;
        size_count  = '0;
        bytes_left  = '0;
        bit_acc     = '0;
        bit_count   = '0;
        esd_index   = '0;
        parse_phase = PH_SIZE;
      end
    endcase
  endtask

  // Driver: present the next request, hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_byte);
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_byte  <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    id_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ids.size() == 0) begin
        $error("unexpected result: kind %0d id %0h tag %0h", kind, id_value, cmd_tag);
        fail_count++;
      end else begin
        e = expected_ids.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          fail_count++;
        end
        if (id_value !== e.id) begin
          $error("id_value: expected %0h, got %0h", e.id, id_value);
          fail_count++;
        end
        if (cmd_tag !== e.tag) begin
          $error("cmd_tag: expected %0h, got %0h", e.tag, cmd_tag);
          fail_count++;
        end
        if (cmd_last !== e.last) begin
          $error("cmd_last: expected %0d, got %0d", e.last, cmd_last);
          fail_count++;
        end
        if (cmd_status !== e.status) begin
          $error("cmd_status: expected %0d, got %0d", e.status, cmd_status);
          fail_count++;
        end
        if (payload_size !== e.size) begin
          $error("payload_size: expected %0h, got %0h", e.size, payload_size);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_tag(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OD_TAG:   od_tag_cfg = val;
      REG_ESD_TAG:  esd_tag_cfg = val;
      REG_IPMP_TAG: ipmp_tag_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_tags(input logic [7:0] od_t, input logic [7:0] esd_t,
                          input logic [7:0] ipmp_t);
    write_tag(REG_OD_TAG, od_t);
    write_tag(REG_ESD_TAG, esd_t);
    write_tag(REG_IPMP_TAG, ipmp_t);
  endtask

  // Hold the sender until every request is in and every result is out
  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || expected_ids.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue one command: tag, size field of at least the minimal length, payload
  task automatic add_command(input logic [7:0] tag, input int unsigned len,
                             input int unsigned pad);
    int unsigned groups;
    int unsigned total;
    int unsigned i;
    logic [7:0] b;
    groups = 1;
    while ((len >> (7 * groups)) != 0) groups++;
    total = groups + pad;
    if (total > MAX_SIZE_BYTES) total = MAX_SIZE_BYTES;
    byte_queue.push_back(tag);
    for (i = total; i > 0; i--) begin
      b = 8'(((len >> (7 * (i - 1))) & 8'h7F) | ((i > 1) ? 8'h80 : 8'h00));
      byte_queue.push_back(b);
    end
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      byte_queue.push_back(b);
    end
  endtask

  task automatic add_random_command();
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // size field that never ends
      b = 8'($urandom_range(255));
      byte_queue.push_back(b);
      for (i = 0; i < MAX_SIZE_BYTES; i++) begin
        b = 8'h80 | 8'($urandom_range(127));
        byte_queue.push_back(b);
      end
    end else begin
      if (pick < 35) b = od_tag_cfg;
      else if (pick < 60) b = esd_tag_cfg;
      else if (pick < 85) b = ipmp_tag_cfg;
      else b = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(12);
      else if (pick < 95) len = $urandom_range(40, 13);
      else len = $urandom_range(300, 41);
      add_command(b, len, $urandom_range(3));
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed commands on the reset tags
    send_idle_pct  = 8;
    recv_stall_pct = 72;
    for (n = 0; n < 26; n++) byte_queue.push_back(directed_bytes[n]);
    drain();

    // Random phases, each under a tag setting; the first and last use the reset tags
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_tags(OD_TAG_RST, ESD_TAG_RST, IPMP_TAG_RST);
        1: set_tags(8'h00, 8'hFF, 8'h80);
        2: set_tags(8'hFF, 8'h00, 8'h00);
        3: set_tags(8'h5A, 8'h5A, 8'h5A);
        4: set_tags(8'h81, 8'h3C, 8'hFF);
        default: set_tags(OD_TAG_RST, ESD_TAG_RST, IPMP_TAG_RST);
      endcase
      if (p < 2) begin
        send_idle_pct  = 8;
        recv_stall_pct = 72;
      end else if (p < 4) begin
        send_idle_pct  = 72;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      n = 0;
      while (n < PHASE_BYTES) begin
        start = byte_queue.size();
        add_random_command();
        n = n + byte_queue.size() - start;
      end
      drain();
    end

    if (fail_count == 0 && expected_ids.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
